FILE: sv/pcxrle_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the PCX run-length decoder.
// No dependencies; every other file imports this package.
package pcxrle_pkg;

    localparam int MAX_DIM     = 4096;
    localparam int DIM_W       = $clog2(MAX_DIM + 1);
    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int COORD_W     = 12;
    localparam int BYTE_W      = 8;
    localparam int RUN_W       = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;
    localparam logic [RUN_W-1:0]  RUN_MASK = 6'h3F;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_LINE_BYTES   = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_reg_index;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_back_state;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              new_image;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0]  pixel_value;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               last_of_run;
        logic               end_of_image;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [CFG_W-1:0]     wr_data;
    } t_cfg_item;

    // One classified byte: a pixel value with its repeat count and a new-image clear flag.
    typedef struct packed {
        logic              clear;
        logic [RUN_W-1:0]  count;
        logic [BYTE_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
        if (int'(v) > MAX_DIM) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

endpackage

FILE: sv/pcxrle_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input bytes, output pixels and config writes.
// Depends on pcxrle_pkg for the payload types.
interface pcxrle_in_if;
    import pcxrle_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcxrle_out_if;
    import pcxrle_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pcxrle_cfg_if;
    import pcxrle_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/pcxrle_queue.sv
`timescale 1ns / 1ps
// Short command queue between the byte classifier and the pixel expander.
// Depends on pcxrle_pkg.
module pcxrle_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  pcxrle_pkg::t_cmd   i_cmd,
    input  logic               i_pop,
    output pcxrle_pkg::t_cmd   o_cmd,
    output pcxrle_pkg::t_q_stat o_stat
);
    import pcxrle_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                push_ok;
    logic                pop_ok;

    assign push_ok      = i_push && (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign pop_ok       = i_pop && (r_count != '0);
    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: sv/pcxrle_front.sv
`timescale 1ns / 1ps
// Byte classifier: pairs run headers with their value byte and emits commands.
// Depends on pcxrle_pkg and pcxrle_if.
module pcxrle_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pcxrle_in_if.sink           i_in,
    input  pcxrle_pkg::t_q_stat i_q_stat,
    output logic                o_push,
    output pcxrle_pkg::t_cmd    o_cmd
);
    import pcxrle_pkg::*;

    logic             r_awaiting;
    logic [RUN_W-1:0] r_pending;
    logic             n_awaiting;
    logic [RUN_W-1:0] n_pending;
    logic             accept;
    logic             awaiting_eff;

    assign i_in.ready   = !i_q_stat.full;
    assign accept       = i_in.valid && i_in.ready;
    assign o_push       = accept;
    // a new image drops any half-seen run header
    assign awaiting_eff = r_awaiting && !i_in.data.new_image;

    always_comb begin
        n_awaiting  = r_awaiting;
        n_pending   = r_pending;
        o_cmd.clear = i_in.data.new_image;
        o_cmd.value = i_in.data.code_byte;
        if (awaiting_eff) begin
            o_cmd.count = r_pending;
            n_awaiting  = 1'b0;
        end else if ((i_in.data.code_byte & RUN_MARK) == RUN_MARK) begin
            o_cmd.count = '0;
            n_awaiting  = 1'b1;
            n_pending   = i_in.data.code_byte[RUN_W-1:0] & RUN_MASK;
        end else begin
            o_cmd.count = RUN_W'(1);
            n_awaiting  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_pending  <= '0;
        end else if (accept) begin
            r_awaiting <= n_awaiting;
            r_pending  <= n_pending;
        end
    end

endmodule

FILE: sv/pcxrle_back.sv
`timescale 1ns / 1ps
// Pixel expander: walks each command over the scan line, holds the position,
// the configuration registers and the output register. Depends on pcxrle_pkg, pcxrle_if.
module pcxrle_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pcxrle_pkg::t_cmd    i_cmd,
    input  pcxrle_pkg::t_q_stat i_q_stat,
    output logic                o_pop,
    pcxrle_out_if.source        o_out,
    pcxrle_cfg_if.sink          i_cfg
);
    import pcxrle_pkg::*;

    t_back_state      r_state;
    t_back_state      n_state;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_lbytes;
    logic [DIM_W-1:0] r_height;
    logic [DIM_W-1:0] r_col;
    logic [DIM_W-1:0] r_row;
    logic             r_finished;
    logic [BYTE_W-1:0] r_value;
    logic [RUN_W-1:0] r_remain;
    logic             r_out_valid;
    t_out_item        r_out;

    logic [DIM_W-1:0] n_col;
    logic [DIM_W-1:0] n_row;
    logic             n_finished;
    logic [RUN_W-1:0] n_remain;
    logic             n_out_valid;
    t_out_item        n_out;

    logic             cfg_wr;
    logic [DIM_W-1:0] cfg_val;
    logic [DIM_W-1:0] sw_max;
    logic [DIM_W-1:0] scan_w;
    logic [DIM_W:0]   col_p1;
    logic [DIM_W:0]   row_p1;
    logic [DIM_W:0]   jump_sum;
    logic             visible;
    logic             is_last;
    logic             cmd_live;
    logic             out_free;
    logic             stall;
    logic             single;
    logic             run_done;
    logic             emit;
    logic             load;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;
    assign cfg_val     = sat_dim(i_cfg.data.wr_data);

    assign sw_max   = (r_width > r_lbytes) ? r_width : r_lbytes;
    assign scan_w   = (sw_max == '0) ? DIM_W'(1) : sw_max;
    assign col_p1   = {1'b0, r_col} + 1'b1;
    assign row_p1   = {1'b0, r_row} + 1'b1;
    assign jump_sum = {1'b0, r_col} + (DIM_W+1)'(r_remain);
    assign visible  = (r_col < r_width);
    // the last visible pixel of a command: run exhausted or padding follows
    assign is_last  = (r_remain == RUN_W'(1)) || (col_p1 >= {1'b0, r_width});
    assign cmd_live = (r_remain != '0) && !r_finished;
    assign out_free = !r_out_valid || o_out.ready;
    assign stall    = cmd_live && visible && !out_free;
    assign single   = cmd_live && visible && !is_last;
    assign run_done = !stall && !single;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (run_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        load = 1'b0;
        emit = 1'b0;
        case (r_state)
            ST_IDLE: load = !i_q_stat.empty;
            ST_RUN:  emit = cmd_live && visible && out_free;
            default: begin
                load = 1'b0;
                emit = 1'b0;
            end
        endcase
    end

    assign o_pop = load;

    // position walk
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_finished = r_finished;
        n_remain   = r_remain;
        if (load) begin
            n_remain = i_cmd.count;
            if (i_cmd.clear) begin
                n_col      = '0;
                n_row      = '0;
                n_finished = (r_height == '0);
            end
        end else if (r_state == ST_RUN && cmd_live && !stall) begin
            if (single) begin
                n_col    = col_p1[DIM_W-1:0];
                n_remain = r_remain - 1'b1;
            end else begin
                // skip the rest of the run in one go; a wrap cuts it off
                n_remain = '0;
                if (jump_sum >= {1'b0, scan_w}) begin
                    n_col = '0;
                    n_row = row_p1[DIM_W-1:0];
                    if (row_p1 >= {1'b0, r_height}) begin
                        n_finished = 1'b1;
                    end
                end else begin
                    n_col = jump_sum[DIM_W-1:0];
                end
            end
        end
        if (cfg_wr && i_cfg.data.reg_index == REG_IMAGE_HEIGHT && r_row >= cfg_val) begin
            n_finished = 1'b1;
        end
    end

    // output register
    always_comb begin
        n_out_valid        = r_out_valid && !o_out.ready;
        n_out              = r_out;
        if (emit) begin
            n_out_valid        = 1'b1;
            n_out.pixel_value  = r_value;
            n_out.column       = COORD_W'(r_col);
            n_out.row          = COORD_W'(r_row);
            n_out.last_of_run  = is_last;
            n_out.end_of_image = (row_p1 == {1'b0, r_height}) &&
                                 (col_p1 == {1'b0, r_width});
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (load) begin
            r_value <= i_cmd.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_width     <= DIM_W'(1);
            r_lbytes    <= DIM_W'(1);
            r_height    <= DIM_W'(1);
            r_col       <= '0;
            r_row       <= '0;
            r_finished  <= 1'b0;
            r_remain    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_col       <= n_col;
            r_row       <= n_row;
            r_finished  <= n_finished;
            r_remain    <= n_remain;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (i_cfg.data.reg_index)
                    REG_IMAGE_WIDTH:  r_width  <= cfg_val;
                    REG_LINE_BYTES:   r_lbytes <= cfg_val;
                    REG_IMAGE_HEIGHT: r_height <= cfg_val;
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: sv/pcx_rle_decoder.sv
`timescale 1ns / 1ps
// A literal byte passes the command queue, the expander's load step and the output register
// before it raises o_out.valid, with the expander idle and the output register free.
// The expander loads one command, then emits its visible pixels, holding while the output
// stalls; it takes no new command until done. Run headers and all-padding runs still load and run.
// Reset (i_rst_n low, synchronous): position cleared, all three size registers
// set to 1, queue and output register emptied; no clearing pass is needed.
module pcx_rle_decoder (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pcxrle_in_if.sink     i_in,
    pcxrle_out_if.source  o_out,
    pcxrle_cfg_if.sink    i_cfg
);
    import pcxrle_pkg::*;

    // Front side: classify bytes into commands (value, count, clear).
    // A run header yields a zero-count command so a new-image clear still
    // reaches the position state in order.
    logic    front_push;
    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    t_q_stat queue_stat;
    logic    back_pop;

    pcxrle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (queue_stat),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    // Decouple: hold up to two commands so the byte side keeps requesting
    // while a long run drains pixel by pixel.
    pcxrle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (back_pop),
        .o_cmd   (queue_cmd),
        .o_stat  (queue_stat)
    );

    // Back side: expand each command along the scan line, drop padding
    // columns in one step, advance the row on a wrap and stop once the
    // image is finished. The output register takes a new pixel in the
    // same cycle that the waiting request is taken.
    pcxrle_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_q_stat (queue_stat),
        .o_pop    (back_pop),
        .o_out    (o_out),
        .i_cfg    (i_cfg)
    );

endmodule

FILE: sv/pcxrle_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the decoder's output channel, bound to the top level.
// Depends on pcxrle_pkg and pcx_rle_decoder.
module pcxrle_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input pcxrle_pkg::t_out_item i_out_item
);
    import pcxrle_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_item))
        else $error("stalled pixel changed or dropped");

    a_eoi_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_item.end_of_image |-> i_out_item.last_of_run)
        else $error("end of image without last of run");

endmodule

bind pcx_rle_decoder pcxrle_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_item  (o_out.data)
);
